// ===== design/histeq_pkg.sv =====
// Shared types and constants for the histogram equalizer.
package histeq_pkg;

	localparam int CHAN_N  = 3;
	localparam int PIX_W   = 8;
	localparam int CNT_W   = 25;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH      = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT     = 2'd2;

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_MAP   = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [PIX_W-1:0] chan0;
		logic [PIX_W-1:0] chan1;
		logic [PIX_W-1:0] chan2;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out0;
		logic [PIX_W-1:0] out1;
		logic [PIX_W-1:0] out2;
	} pix_out_t;

	typedef struct packed {
		logic [CHAN_N-1:0][PIX_W-1:0] rd_addr;
		logic [CHAN_N-1:0]            we;
		logic [CHAN_N-1:0][PIX_W-1:0] wr_addr;
		logic [CHAN_N-1:0][CNT_W-1:0] wr_data;
	} cnt_req_t;

	typedef struct packed {
		logic [CHAN_N-1:0][PIX_W-1:0] rd_addr;
		logic                         we;
		logic [PIX_W-1:0]             wr_addr;
		logic [CHAN_N-1:0][PIX_W-1:0] wr_data;
	} map_req_t;

endpackage

// ===== design/histeq_count_ram.sv =====
// Per-channel bin count memories, one read and one write port each.
module histeq_count_ram (
	input  logic                                          clk,
	input  histeq_pkg::cnt_req_t                          req,
	output logic [histeq_pkg::CHAN_N-1:0][histeq_pkg::CNT_W-1:0] rd_data
);
	import histeq_pkg::*;

	logic [CNT_W-1:0] mem0 [2**PIX_W];
	logic [CNT_W-1:0] mem1 [2**PIX_W];
	logic [CNT_W-1:0] mem2 [2**PIX_W];

	// Write and read each bank
	always_ff @(posedge clk) begin
		if (req.we[0]) mem0[req.wr_addr[0]] <= req.wr_data[0];
		if (req.we[1]) mem1[req.wr_addr[1]] <= req.wr_data[1];
		if (req.we[2]) mem2[req.wr_addr[2]] <= req.wr_data[2];
		rd_data[0] <= mem0[req.rd_addr[0]];
		rd_data[1] <= mem1[req.rd_addr[1]];
		rd_data[2] <= mem2[req.rd_addr[2]];
	end

endmodule

// ===== design/histeq_map_ram.sv =====
// Per-channel lookup table memories.
module histeq_map_ram (
	input  logic                                          clk,
	input  histeq_pkg::map_req_t                          req,
	output logic [histeq_pkg::CHAN_N-1:0][histeq_pkg::PIX_W-1:0] rd_data
);
	import histeq_pkg::*;

	logic [PIX_W-1:0] mem0 [2**PIX_W];
	logic [PIX_W-1:0] mem1 [2**PIX_W];
	logic [PIX_W-1:0] mem2 [2**PIX_W];

	// Write all banks at one bin, read each at its own address
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem0[req.wr_addr] <= req.wr_data[0];
			mem1[req.wr_addr] <= req.wr_data[1];
			mem2[req.wr_addr] <= req.wr_data[2];
		end
		rd_data[0] <= mem0[req.rd_addr[0]];
		rd_data[1] <= mem1[req.rd_addr[1]];
		rd_data[2] <= mem2[req.rd_addr[2]];
	end

endmodule

// ===== design/histeq_div.sv =====
// Three-lane restoring divider giving a saturated 8-bit quotient.
module histeq_div #(
	parameter int DEN_W = 26
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [histeq_pkg::CHAN_N-1:0][DEN_W+7:0]      num,
	input  logic [DEN_W-1:0]                              den,
	output logic                                          done,
	output logic [histeq_pkg::CHAN_N-1:0][histeq_pkg::PIX_W-1:0] quo
);
	import histeq_pkg::*;

	localparam int NUM_W = DEN_W + 8;

	logic                                busy_q;
	logic [2:0]                          step_q;
	logic [NUM_W-1:0]                    dsh_q;
	logic [CHAN_N-1:0][NUM_W-1:0]        rem_q;
	logic [CHAN_N-1:0][PIX_W-1:0]        q_q;
	logic [CHAN_N-1:0]                   sat_q;
	logic [NUM_W-1:0]                    den_full;

	assign den_full = {den, 8'd0};

	// Control: eight steps after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath: one quotient bit per cycle, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= {1'b0, den, 7'd0};
			for (int c = 0; c < CHAN_N; c++) begin
				rem_q[c] <= num[c];
				sat_q[c] <= (num[c] >= den_full);
				q_q[c]   <= '0;
			end
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			for (int c = 0; c < CHAN_N; c++) begin
				q_q[c] <= {q_q[c][PIX_W-2:0], (rem_q[c] >= dsh_q)};
				if (rem_q[c] >= dsh_q) rem_q[c] <= rem_q[c] - dsh_q;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CHAN_N; c++) quo[c] = sat_q[c] ? {PIX_W{1'b1}} : q_q[c];
	end

endmodule

// ===== design/histogram_equalizer_unit.sv =====
// Histogram equalizer: bin counts and lookup tables held in synchronous memories.
// Accumulate item: read, then increment and write back. Map item: table read, then result
// registered; the next item is taken after the map step. The last pixel
// of an image adds a table build over 256 bins (read, sum, scale, 8-step divide per bin)
// during which input stalls.
// Reset: config returns to gray, 1x1; a clearing pass over all 256 bins zeroes the counts.
module histogram_equalizer_unit #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  histeq_pkg::pix_in_t          in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output histeq_pkg::pix_out_t         out_data,
	input  logic                         cfg_we,
	input  logic [histeq_pkg::IDX_W-1:0] cfg_index,
	input  logic [histeq_pkg::CFG_W-1:0] cfg_data
);
	import histeq_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int AREA_W = 2 * SIDE_W;
	localparam int CMP_W  = (AREA_W > CNT_W) ? AREA_W : CNT_W;
	localparam int NUM_W  = CMP_W + 8;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_MAP  = 3'd3;
	localparam logic [2:0] ST_BRD  = 3'd4;
	localparam logic [2:0] ST_BACC = 3'd5;
	localparam logic [2:0] ST_BMUL = 3'd6;
	localparam logic [2:0] ST_BDIV = 3'd7;

	logic [2:0]                     state_q;
	logic                           mode_q;
	logic [CFG_W-1:0]               width_q;
	logic [CFG_W-1:0]               height_q;
	logic [AREA_W-1:0]              area_q;
	logic [SIDE_W-1:0]              side_w;
	logic [SIDE_W-1:0]              side_h;
	logic [CNT_W-1:0]               pix_cnt_q;
	logic [CNT_W-1:0]               pix_cnt_nxt;
	logic                           table_ready_q;
	logic [PIX_W-1:0]               bin_q;
	pix_in_t                        pix_s1;
	logic [CHAN_N-1:0][CMP_W-1:0]   cdf_q;
	logic [CHAN_N-1:0][NUM_W-1:0]   num;
	logic                           div_start;
	logic                           div_done;
	logic [CHAN_N-1:0][PIX_W-1:0]   div_quo;
	cnt_req_t                       cnt_req;
	map_req_t                       map_req;
	logic [CHAN_N-1:0][CNT_W-1:0]   cnt_rd;
	logic [CHAN_N-1:0][PIX_W-1:0]   map_rd;
	logic                           in_acc;
	logic                           out_valid_q;
	pix_out_t                       out_q;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pix_cnt_nxt = pix_cnt_q + CNT_W'(1);
	assign div_start = (state_q == ST_BMUL);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_MODE: mode_q   <= cfg_data[0];
				REG_WIDTH:      width_q  <= cfg_data;
				REG_HEIGHT:     height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp sides and register the image area
	always_comb begin
		if (width_q == '0) side_w = SIDE_W'(1);
		else if (CMP_W'(width_q) > CMP_W'(MAX_SIDE)) side_w = SIDE_W'(MAX_SIDE);
		else side_w = SIDE_W'(width_q);
		if (height_q == '0) side_h = SIDE_W'(1);
		else if (CMP_W'(height_q) > CMP_W'(MAX_SIDE)) side_h = SIDE_W'(MAX_SIDE);
		else side_h = SIDE_W'(height_q);
	end

	always_ff @(posedge clk) begin
		area_q <= AREA_W'(side_w) * AREA_W'(side_h);
	end

	// Scale running sums by 255 as a shift and subtract
	always_comb begin
		for (int c = 0; c < CHAN_N; c++)
			num[c] = {cdf_q[c], 8'd0} - NUM_W'(cdf_q[c]);
	end

	// Count memory requests
	always_comb begin
		cnt_req = '0;
		for (int c = 0; c < CHAN_N; c++) begin
			cnt_req.rd_addr[c] = bin_q;
			cnt_req.wr_addr[c] = bin_q;
		end
		if (state_q == ST_IDLE) begin
			cnt_req.rd_addr[0] = in_data.chan0;
			cnt_req.rd_addr[1] = in_data.chan1;
			cnt_req.rd_addr[2] = in_data.chan2;
		end
		case (state_q)
			ST_CLR, ST_BACC: cnt_req.we = '1;
			ST_ACC: begin
				cnt_req.we = {mode_q, mode_q, 1'b1};
				cnt_req.wr_addr[0] = pix_s1.chan0;
				cnt_req.wr_addr[1] = pix_s1.chan1;
				cnt_req.wr_addr[2] = pix_s1.chan2;
				for (int c = 0; c < CHAN_N; c++)
					cnt_req.wr_data[c] = cnt_rd[c] + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// Map memory requests
	always_comb begin
		map_req = '0;
		map_req.rd_addr[0] = in_data.chan0;
		map_req.rd_addr[1] = in_data.chan1;
		map_req.rd_addr[2] = in_data.chan2;
		map_req.we      = (state_q == ST_BDIV) && div_done;
		map_req.wr_addr = bin_q;
		map_req.wr_data = div_quo;
	end

	histeq_count_ram u_cnt (
		.clk     (clk),
		.req     (cnt_req),
		.rd_data (cnt_rd)
	);

	histeq_map_ram u_map (
		.clk     (clk),
		.req     (map_req),
		.rd_data (map_rd)
	);

	histeq_div #(
		.DEN_W (CMP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (CMP_W'(area_q)),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) pix_s1 <= in_data;
	end

	// Sequencer: clear, accumulate, map, build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			bin_q         <= '0;
			pix_cnt_q     <= '0;
			table_ready_q <= 1'b0;
			cdf_q         <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					bin_q <= bin_q + PIX_W'(1);
					if (&bin_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) state_q <= (in_data.opcode == OP_MAP) ? ST_MAP : ST_ACC;
				end
				ST_ACC: begin
					pix_cnt_q <= pix_cnt_nxt;
					if (CMP_W'(pix_cnt_nxt) >= CMP_W'(area_q)) begin
						state_q <= ST_BRD;
						bin_q   <= '0;
						cdf_q   <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAP: state_q <= ST_IDLE;
				ST_BRD: state_q <= ST_BACC;
				ST_BACC: begin
					for (int c = 0; c < CHAN_N; c++)
						cdf_q[c] <= cdf_q[c] + CMP_W'(cnt_rd[c]);
					state_q <= ST_BMUL;
				end
				ST_BMUL: state_q <= ST_BDIV;
				ST_BDIV: begin
					if (div_done) begin
						bin_q <= bin_q + PIX_W'(1);
						if (&bin_q) begin
							state_q       <= ST_IDLE;
							pix_cnt_q     <= '0;
							table_ready_q <= 1'b1;
						end else begin
							state_q <= ST_BRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load on map, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_MAP) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			out_q.out0 <= table_ready_q ? map_rd[0] : '0;
			out_q.out1 <= (table_ready_q && mode_q) ? map_rd[1] : '0;
			out_q.out2 <= (table_ready_q && mode_q) ? map_rd[2] : '0;
		end
	end

`ifndef ASSERT_OFF
	a_out_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MAP))
		else $error("result raised outside map step");
	a_build_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BDIV) && div_done && (&bin_q) |=>
		table_ready_q && (pix_cnt_q == '0) && (state_q == ST_IDLE))
		else $error("table build did not finish cleanly");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR || state_q == ST_BDIV || state_q == ST_BRD) |-> !in_ready)
		else $error("item accepted while memory busy");
`endif

endmodule
